/* rtl/core/assert_macros.svh */
// Assertion macros used by the block decoder top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds in the same cycle as its trigger.
`define ASSERT_SAME(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

/* rtl/core/lz4d_pkg.sv */
// Shared types and constants for the block decoder.
`default_nettype none
package lz4d_pkg;

    localparam int WINDOW_SIZE_DEF = 65536;
    localparam int CMD_DEPTH       = 4;
    localparam int OUT_DEPTH       = 2;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_LIT   = 2'd1,
        KIND_MATCH = 2'd2,
        KIND_ERR   = 2'd3
    } kind_t;

    // Control part of one decoded beat.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       copy_pending;
        logic       done;
    } beat_ctl_t;

endpackage
`default_nettype wire

/* rtl/core/lz4d_fifo.sv */
// Small register queue used between and after the decoder stages.
`default_nettype none
module lz4d_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = store_reg[rd_ptr_reg];

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming beat
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/lz4d_front.sv */
// Front end: parses compressed bytes and copy steps into history commands.
`default_nettype none
module lz4d_front #(
    parameter int WINDOW_SIZE = lz4d_pkg::WINDOW_SIZE_DEF,
    parameter int AW          = $clog2(WINDOW_SIZE)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire logic                opcode,
    input  wire logic [7:0]          data_byte,
    input  wire logic                block_end,
    input  wire logic                cfg_valid,
    input  wire logic [31:0]         cfg_data,
    output lz4d_pkg::beat_ctl_t      cmd_ctl,
    output logic [AW-1:0]            cmd_raddr,
    output logic [AW-1:0]            cmd_waddr
);
    import lz4d_pkg::*;

    typedef enum logic [7:0] {
        PH_TOKEN    = 8'b0000_0001,
        PH_LITEXT   = 8'b0000_0010,
        PH_LIT      = 8'b0000_0100,
        PH_OFFLO    = 8'b0000_1000,
        PH_OFFHI    = 8'b0001_0000,
        PH_MATCHEXT = 8'b0010_0000,
        PH_COPY     = 8'b0100_0000,
        PH_DRAIN    = 8'b1000_0000
    } phase_t;

    localparam logic [16:0] WIN17 = 17'(WINDOW_SIZE);

    phase_t        phase_reg, phase_next;
    logic [AW-1:0] wp_reg, wp_next, wp_inc;
    logic [31:0]   bp_reg, bp_next, bp_inc;
    logic [3:0]    nib_reg, nib_next;
    logic [31:0]   lit_left_reg, lit_left_next;
    logic [31:0]   match_left_reg, match_left_next;
    logic [15:0]   off_reg, off_next, off_full;
    logic [31:0]   limit_reg;
    logic [16:0]   wp17, off17, src17;
    logic [32:0]   lit_sum, match_sum;
    logic [31:0]   lit_dec, match_dec;
    logic          hit_after_put;
    logic          err, ended;
    kind_t         kind_c;
    logic [7:0]    obyte_c;
    logic          done_c;

    // Hold the output limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= '0;
        end
        else if (cfg_valid)
        begin
            limit_reg <= cfg_data;
        end
    end

    // Shared arithmetic for this beat
    always_comb
    begin
        wp_inc        = (wp_reg == AW'(WINDOW_SIZE - 1)) ? '0 : wp_reg + 1'b1;
        bp_inc        = (bp_reg == '1) ? bp_reg : bp_reg + 1'b1;
        hit_after_put = (limit_reg != '0) && (bp_inc >= limit_reg);
        wp17          = 17'(wp_reg);
        off17         = {1'b0, off_reg};
        src17         = (wp17 >= off17) ? wp17 - off17 : wp17 + WIN17 - off17;
        lit_sum       = {1'b0, lit_left_reg} + {25'd0, data_byte};
        match_sum     = {1'b0, match_left_reg} + {25'd0, data_byte};
        lit_dec       = lit_left_reg - 1'b1;
        match_dec     = match_left_reg - 1'b1;
        off_full      = {data_byte, off_reg[7:0]};
    end

    // Parse one beat
    always_comb
    begin
        phase_next      = phase_reg;
        wp_next         = wp_reg;
        bp_next         = bp_reg;
        nib_next        = nib_reg;
        lit_left_next   = lit_left_reg;
        match_left_next = match_left_reg;
        off_next        = off_reg;
        err             = 1'b0;
        ended           = 1'b0;
        kind_c          = KIND_NONE;
        obyte_c         = 8'd0;
        done_c          = 1'b0;

        if (opcode)
        begin
            if (phase_reg == PH_COPY)
            begin
                kind_c          = KIND_MATCH;
                wp_next         = wp_inc;
                bp_next         = bp_inc;
                match_left_next = match_dec;
                if (hit_after_put)
                begin
                    phase_next = PH_DRAIN;
                    done_c     = 1'b1;
                end
                else if (match_dec == '0)
                begin
                    phase_next = PH_TOKEN;
                end
            end
            else if (phase_reg == PH_DRAIN)
            begin
                done_c = 1'b1;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_TOKEN:
                begin
                    nib_next      = data_byte[3:0];
                    lit_left_next = {28'd0, data_byte[7:4]};
                    if (data_byte[7:4] == 4'hF)
                    begin
                        phase_next = PH_LITEXT;
                    end
                    else if (data_byte[7:4] != 4'h0)
                    begin
                        phase_next = PH_LIT;
                    end
                    else if (!block_end)
                    begin
                        phase_next = PH_OFFLO;
                    end
                    ended = block_end && (data_byte[7:4] == 4'h0);
                    err   = block_end && (data_byte[7:4] != 4'h0);
                end
                PH_LITEXT:
                begin
                    lit_left_next = lit_sum[32] ? '1 : lit_sum[31:0];
                    if (data_byte != 8'hFF)
                    begin
                        phase_next = PH_LIT;
                    end
                    err = block_end;
                end
                PH_LIT:
                begin
                    if (block_end && (lit_left_reg != 32'd1))
                    begin
                        err = 1'b1;
                    end
                    else
                    begin
                        kind_c        = KIND_LIT;
                        obyte_c       = data_byte;
                        wp_next       = wp_inc;
                        bp_next       = bp_inc;
                        lit_left_next = lit_dec;
                        if (block_end)
                        begin
                            ended = 1'b1;
                        end
                        else if (hit_after_put)
                        begin
                            phase_next = PH_DRAIN;
                            done_c     = 1'b1;
                        end
                        else if (lit_dec == '0)
                        begin
                            phase_next = PH_OFFLO;
                        end
                    end
                end
                PH_OFFLO:
                begin
                    off_next   = {8'd0, data_byte};
                    phase_next = PH_OFFHI;
                    err        = block_end;
                end
                PH_OFFHI:
                begin
                    off_next = off_full;
                    if (block_end || (off_full == '0) || ({16'd0, off_full} > bp_reg)
                        || ({1'b0, off_full} > WIN17))
                    begin
                        err = 1'b1;
                    end
                    else
                    begin
                        match_left_next = {28'd0, nib_reg} + 32'd4;
                        phase_next      = (nib_reg == 4'hF) ? PH_MATCHEXT : PH_COPY;
                    end
                end
                PH_MATCHEXT:
                begin
                    match_left_next = match_sum[32] ? '1 : match_sum[31:0];
                    if (data_byte != 8'hFF)
                    begin
                        phase_next = PH_COPY;
                    end
                    err = block_end;
                end
                PH_COPY:
                begin
                    err = 1'b1;
                end
                PH_DRAIN:
                begin
                    done_c = 1'b1;
                    ended  = block_end;
                end
                default:
                begin
                    err = 1'b1;
                end
            endcase
        end

        // Resolve errors and block end
        if (err)
        begin
            kind_c     = KIND_ERR;
            obyte_c    = 8'd0;
            done_c     = 1'b1;
            phase_next = block_end ? PH_TOKEN : PH_DRAIN;
            if (block_end)
            begin
                bp_next = '0;
            end
        end
        else if (ended)
        begin
            done_c     = 1'b1;
            phase_next = PH_TOKEN;
            bp_next    = '0;
        end
    end

    assign cmd_ctl.kind         = kind_c;
    assign cmd_ctl.data         = obyte_c;
    assign cmd_ctl.copy_pending = (phase_next == PH_COPY);
    assign cmd_ctl.done         = done_c;
    assign cmd_raddr            = src17[AW-1:0];
    assign cmd_waddr            = wp_reg;

    // Advance parser state on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_TOKEN;
            wp_reg         <= '0;
            bp_reg         <= '0;
            nib_reg        <= '0;
            lit_left_reg   <= '0;
            match_left_reg <= '0;
            off_reg        <= '0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            wp_reg         <= wp_next;
            bp_reg         <= bp_next;
            nib_reg        <= nib_next;
            lit_left_reg   <= lit_left_next;
            match_left_reg <= match_left_next;
            off_reg        <= off_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/lz4d_back.sv */
// Back end: history RAM access, match byte lookup and write-back.
`default_nettype none
module lz4d_back #(
    parameter int WINDOW_SIZE = lz4d_pkg::WINDOW_SIZE_DEF,
    parameter int AW          = $clog2(WINDOW_SIZE)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cmd_valid,
    input  wire lz4d_pkg::beat_ctl_t  cmd_ctl,
    input  wire logic [AW-1:0]        cmd_raddr,
    input  wire logic [AW-1:0]        cmd_waddr,
    output logic                      cmd_pop,
    input  wire logic                 out_full,
    output logic                      out_push,
    output lz4d_pkg::beat_ctl_t       out_ctl
);
    import lz4d_pkg::*;

    logic [7:0]    hist_mem [WINDOW_SIZE];
    logic          a_valid_reg;
    beat_ctl_t     a_ctl_reg;
    logic [AW-1:0] a_waddr_reg;
    logic [7:0]    rdata_reg;
    logic          fwd_hit_reg;
    logic [7:0]    fwd_data_reg;
    logic          a_leave, a_enter, a_we;
    logic [7:0]    a_byte;

    assign a_leave = a_valid_reg && !out_full;
    assign a_enter = cmd_valid && (!a_valid_reg || a_leave);
    assign cmd_pop = a_enter;
    assign a_we    = (a_ctl_reg.kind == KIND_LIT) || (a_ctl_reg.kind == KIND_MATCH);

    // Pick the match byte, bypassing a write made on the read edge
    always_comb
    begin
        a_byte = a_ctl_reg.data;
        if (a_ctl_reg.kind == KIND_MATCH)
        begin
            a_byte = fwd_hit_reg ? fwd_data_reg : rdata_reg;
        end
        out_ctl      = a_ctl_reg;
        out_ctl.data = a_byte;
    end

    assign out_push = a_leave;

    // Track the stage occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_enter)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (a_leave)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    // Load the stage payload and bypass flag
    always_ff @(posedge clk)
    begin
        if (a_enter)
        begin
            a_ctl_reg    <= cmd_ctl;
            a_waddr_reg  <= cmd_waddr;
            fwd_hit_reg  <= a_leave && a_we && (a_waddr_reg == cmd_raddr);
            fwd_data_reg <= a_byte;
        end
    end

    // History RAM: write on leave, read on enter
    always_ff @(posedge clk)
    begin
        if (a_leave && a_we)
        begin
            hist_mem[a_waddr_reg] <= a_byte;
        end
        if (a_enter)
        begin
            rdata_reg <= hist_mem[cmd_raddr];
        end
    end

endmodule
`default_nettype wire

/* rtl/core/lz4_block_decoder.sv */
// An accepted beat passes the command queue, the history stage register and the result queue.
// Throughput: one item per cycle while neither queue is full, set by the one read and one write port of history.
// A match byte written on the same edge as its read is bypassed, so no stall arises.
// Reset clears parser state, queues and output limit; history stays undefined
// and needs no clearing pass, so items are taken from the first cycle after reset.
`default_nettype none
module lz4_block_decoder #(
    parameter int WINDOW_SIZE = lz4d_pkg::WINDOW_SIZE_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        opcode,
    input  wire logic [7:0]  data_byte,
    input  wire logic        block_end,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       out_byte,
    output logic [1:0]       kind,
    output logic             copy_pending,
    output logic             block_done,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data
);
    import lz4d_pkg::*;

    `include "assert_macros.svh"

    localparam int AW    = $clog2(WINDOW_SIZE);
    localparam int CTL_W = $bits(beat_ctl_t);
    localparam int CMD_W = CTL_W + 2 * AW;

    logic              accept;
    beat_ctl_t         f_ctl, b_ctl, o_ctl, q_ctl;
    logic [AW-1:0]     f_raddr, f_waddr, q_raddr, q_waddr;
    logic [CMD_W-1:0]  cmd_wdata, cmd_rdata;
    logic              cmd_empty, cmd_pop;
    logic              out_full, out_push;
    logic [CTL_W-1:0]  out_rdata;

    assign accept    = push && !full;
    assign cfg_ready = 1'b1;

    lz4d_front #(.WINDOW_SIZE(WINDOW_SIZE), .AW(AW)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .opcode    (opcode),
        .data_byte (data_byte),
        .block_end (block_end),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .cmd_ctl   (f_ctl),
        .cmd_raddr (f_raddr),
        .cmd_waddr (f_waddr)
    );

    // Queue commands between parser and history side
    assign cmd_wdata = {f_ctl, f_raddr, f_waddr};

    lz4d_fifo #(.WIDTH(CMD_W), .DEPTH(CMD_DEPTH)) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .wdata (cmd_wdata),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd_rdata),
        .empty (cmd_empty)
    );

    assign {q_ctl, q_raddr, q_waddr} = cmd_rdata;

    lz4d_back #(.WINDOW_SIZE(WINDOW_SIZE), .AW(AW)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!cmd_empty),
        .cmd_ctl   (q_ctl),
        .cmd_raddr (q_raddr),
        .cmd_waddr (q_waddr),
        .cmd_pop   (cmd_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_ctl   (b_ctl)
    );

    // Buffer results so the back end keeps going while a result waits
    lz4d_fifo #(.WIDTH(CTL_W), .DEPTH(OUT_DEPTH)) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (b_ctl),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_rdata),
        .empty (empty)
    );

    assign o_ctl        = out_rdata;
    assign out_byte     = o_ctl.data;
    assign kind         = o_ctl.kind;
    assign copy_pending = o_ctl.copy_pending;
    assign block_done   = o_ctl.done;

    `ASSERT_SAME(a_nobyte_zero, !empty && (kind == KIND_NONE || kind == KIND_ERR),
                 out_byte == 8'd0, "result without a byte carries nonzero data")
    `ASSERT_SAME(a_err_done, !empty && (kind == KIND_ERR), block_done,
                 "error result without block done")
    `ASSERT_SAME(a_copy_not_done, !empty, !(copy_pending && block_done),
                 "copy pending on a finished block")

endmodule
`default_nettype wire
